[hdl/image_datagram_segmenter_defines.svh]
// ============================================================================
// image_datagram_segmenter_defines.svh
// Assertion macros for the image datagram segmenter. They are empty when
// SYNTHESIS is defined.
// ============================================================================
`ifndef IMAGE_DATAGRAM_SEGMENTER_DEFINES_SVH
`define IMAGE_DATAGRAM_SEGMENTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define IDSG_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("idsg assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define IDSG_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idsg assertion failed");
`else
`define IDSG_ASSERT_IMP(name, ante, cons)
`define IDSG_ASSERT_NXT(name, ante, cons)
`endif

`endif

[hdl/idsg_pkg.sv]
// ============================================================================
// idsg_pkg
// Shared widths, codes, state and command types of the datagram segmenter.
// ============================================================================
package idsg_pkg;

	localparam int BYTE_W    = 8;
	localparam int PAYLOAD_W = 16;
	localparam int LEN_W     = 24;
	localparam int IDX_W     = 24;
	localparam int SEL_W     = 2;   // index byte select, up to four bytes
	localparam int DIV_W     = LEN_W + 1;
	localparam int DIV_STEPS = DIV_W;
	localparam int DIV_CNT_W = 5;
	localparam int CNT_W     = 16;  // header packet count width

	localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 16'd1000;

	// input word kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TYPE,
		ST_DIV,
		ST_CNT_LO,
		ST_CNT_HI,
		ST_EMPTY,
		ST_EMPTY_LAST,
		ST_ERR,
		ST_INDEX,
		ST_DATA,
		ST_TERM
	} state_t;

	// kind of result word loaded into the output register
	typedef enum logic [2:0] {
		K_TYPE,
		K_CNT_LO,
		K_CNT_HI,
		K_EMPTY,
		K_EMPTY_LAST,
		K_ERR,
		K_INDEX,
		K_DATA
	} kind_t;

	typedef struct packed {
		logic  accept_start;
		logic  accept_data;
		logic  emit;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic can_data;    // image open with bytes left
		logic pos_zero;    // next data byte opens a chunk
		logic len_zero;    // current image has zero length
		logic div_done;    // packet count ready
		logic last_index;  // index byte select on its last byte
		logic finished;    // pending data byte is the image's last
		logic load_ok;     // output register can take a word
	} status_t;

endpackage

[hdl/image_datagram_segmenter.sv]
// ============================================================================
// image_datagram_segmenter
// Cuts an image byte stream into datagrams: a type/count header, indexed
// payload chunks and an empty terminator datagram.
// ============================================================================
//
//   channel  dir  handshake              payload
//   -------  ---  ---------------------  ------------------------------------
//   s_axis   in   s_axis_tvalid/tready   tdata: type, length, byte; tuser: kind
//   m_axis   out  m_axis_tvalid/tready   tdata: byte; tuser: end/empty/error
//   cfg      in   cfg_we                 cfg_wdata: payload bytes per datagram
//
// One input word at a time. A data word emits INDEX_BYTES index bytes first
// when it opens a chunk, then its data byte, and the terminator after the last.
// A start word emits the type byte, waits for the bit-serial packet count
// divider (25 steps for a 25-bit numerator) and emits the two count bytes.
// A result word waits in the output register while the next input is taken.
// Output stalls hold the sequencer. Reset closes any open image and loads the
// payload register with 1000.
//
module image_datagram_segmenter #(
	parameter int INDEX_BYTES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // image_type[7:0], total_length[31:8], data_byte[39:32]
	input  logic [0:0]  s_axis_tuser,   // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
	output logic [2:0]  m_axis_tuser,   // datagram_end[0], empty_datagram[1], error[2]
	output logic        m_axis_tlast    // run_last
);

`include "image_datagram_segmenter_defines.svh"

	idsg_pkg::cmd_t    cmd;
	idsg_pkg::status_t status;

	// sequencer
	idsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_req   (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	idsg_dp #(
		.INDEX_BYTES (INDEX_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_image_type   (s_axis_tdata[7:0]),
		.in_total_length (s_axis_tdata[31:8]),
		.in_data_byte    (s_axis_tdata[39:32]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_byte        (m_axis_tdata),
		.out_end         (m_axis_tuser[0]),
		.out_empty       (m_axis_tuser[1]),
		.out_last        (m_axis_tlast),
		.out_error       (m_axis_tuser[2])
	);

	// a start word keeps the input closed in the next cycle
	`IDSG_ASSERT_NXT(a_start_busy, cmd.accept_start, !s_axis_tready)
	// an error word is always the last of its run
	`IDSG_ASSERT_IMP(a_err_last, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)
	// an empty datagram both opens and closes
	`IDSG_ASSERT_IMP(a_empty_end, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

endmodule

[hdl/idsg_ctrl.sv]
// ============================================================================
// idsg_ctrl
// Sequencer: takes one input word at a time and steps through the result
// words it causes, one per cycle while the output side keeps up, apart from
// the wait for the packet count on a start word.
// ============================================================================
module idsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req,
	output logic              in_ready,
	input  idsg_pkg::status_t status,
	output idsg_pkg::cmd_t    cmd
);

	idsg_pkg::state_t state_q;
	idsg_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			idsg_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_req == idsg_pkg::REQ_START) begin
						state_nxt = idsg_pkg::ST_TYPE;
					end else if (!status.can_data) begin
						state_nxt = idsg_pkg::ST_ERR;
					end else if (status.pos_zero) begin
						state_nxt = idsg_pkg::ST_INDEX;
					end else begin
						state_nxt = idsg_pkg::ST_DATA;
					end
				end
			end
			idsg_pkg::ST_TYPE: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_DIV;
			end
			idsg_pkg::ST_DIV: begin
				if (status.div_done) state_nxt = idsg_pkg::ST_CNT_LO;
			end
			idsg_pkg::ST_CNT_LO: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_CNT_HI;
			end
			idsg_pkg::ST_CNT_HI: begin
				if (status.load_ok) begin
					state_nxt = status.len_zero ? idsg_pkg::ST_EMPTY : idsg_pkg::ST_IDLE;
				end
			end
			idsg_pkg::ST_EMPTY: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_EMPTY_LAST;
			end
			idsg_pkg::ST_EMPTY_LAST: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_IDLE;
			end
			idsg_pkg::ST_ERR: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_IDLE;
			end
			idsg_pkg::ST_INDEX: begin
				if (status.load_ok && status.last_index) state_nxt = idsg_pkg::ST_DATA;
			end
			idsg_pkg::ST_DATA: begin
				if (status.load_ok) begin
					state_nxt = status.finished ? idsg_pkg::ST_TERM : idsg_pkg::ST_IDLE;
				end
			end
			idsg_pkg::ST_TERM: begin
				if (status.load_ok) state_nxt = idsg_pkg::ST_IDLE;
			end
			default: state_nxt = idsg_pkg::ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		in_ready         = (state_q == idsg_pkg::ST_IDLE);
		cmd.accept_start = in_ready && in_valid && (in_req == idsg_pkg::REQ_START);
		cmd.accept_data  = in_ready && in_valid && (in_req == idsg_pkg::REQ_DATA);
		cmd.emit         = 1'b0;
		cmd.kind         = idsg_pkg::K_TYPE;
		unique case (state_q)
			idsg_pkg::ST_IDLE: begin
				cmd.emit = 1'b0;
			end
			idsg_pkg::ST_DIV: begin
				cmd.emit = 1'b0;
			end
			idsg_pkg::ST_TYPE: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_TYPE;
			end
			idsg_pkg::ST_CNT_LO: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_CNT_LO;
			end
			idsg_pkg::ST_CNT_HI: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_CNT_HI;
			end
			idsg_pkg::ST_EMPTY: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_EMPTY;
			end
			idsg_pkg::ST_EMPTY_LAST, idsg_pkg::ST_TERM: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_EMPTY_LAST;
			end
			idsg_pkg::ST_ERR: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_ERR;
			end
			idsg_pkg::ST_INDEX: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_INDEX;
			end
			idsg_pkg::ST_DATA: begin
				cmd.emit = status.load_ok;
				cmd.kind = idsg_pkg::K_DATA;
			end
			default: cmd.emit = 1'b0;
		endcase
	end

endmodule

[hdl/idsg_dp.sv]
// ============================================================================
// idsg_dp
// Datapath: image state, payload register, packet count divider, result
// word selection and the output register.
// ============================================================================
module idsg_dp #(
	parameter int INDEX_BYTES = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  idsg_pkg::cmd_t                      cmd,
	output idsg_pkg::status_t                   status,
	input  logic                                cfg_we,
	input  logic [idsg_pkg::PAYLOAD_W-1:0]      cfg_wdata,
	input  logic [idsg_pkg::BYTE_W-1:0]         in_image_type,
	input  logic [idsg_pkg::LEN_W-1:0]          in_total_length,
	input  logic [idsg_pkg::BYTE_W-1:0]         in_data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [idsg_pkg::BYTE_W-1:0]         out_byte,
	output logic                                out_end,
	output logic                                out_empty,
	output logic                                out_last,
	output logic                                out_error
);

	localparam logic [idsg_pkg::SEL_W-1:0] SEL_LAST = idsg_pkg::SEL_W'(INDEX_BYTES - 1);

	logic [idsg_pkg::PAYLOAD_W-1:0] payload_q;
	logic [idsg_pkg::PAYLOAD_W-1:0] p_eff;
	logic [idsg_pkg::LEN_W-1:0]     bytes_left_q;
	logic [idsg_pkg::PAYLOAD_W-1:0] chunk_pos_q;
	logic [idsg_pkg::IDX_W-1:0]     chunk_idx_q;
	logic                           image_open_q;
	logic                           len_zero_q;
	logic [idsg_pkg::BYTE_W-1:0]    type_q;
	logic [idsg_pkg::BYTE_W-1:0]    data_q;
	logic [idsg_pkg::SEL_W-1:0]     sel_q;

	logic [idsg_pkg::PAYLOAD_W-1:0] rem_q;
	logic [idsg_pkg::DIV_W-1:0]     num_q;
	logic [idsg_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                           div_busy_q;
	logic [idsg_pkg::PAYLOAD_W:0]   div_shift;
	logic [idsg_pkg::PAYLOAD_W:0]   div_diff;
	logic                           div_ge;
	logic [idsg_pkg::DIV_W-1:0]     div_init;

	logic [idsg_pkg::PAYLOAD_W-1:0] pos_inc;
	logic                           finished;
	logic                           closes;
	logic [idsg_pkg::BYTE_W-1:0]    idx_byte;

	logic                           out_valid_q;
	logic [idsg_pkg::BYTE_W-1:0]    out_byte_q;
	logic                           out_end_q;
	logic                           out_empty_q;
	logic                           out_last_q;
	logic                           out_error_q;
	logic [idsg_pkg::BYTE_W-1:0]    nxt_byte;
	logic                           nxt_end;
	logic                           nxt_empty;
	logic                           nxt_last;
	logic                           nxt_error;

	// payload register, zero reads as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= idsg_pkg::PAYLOAD_RESET;
		end else if (cfg_we) begin
			payload_q <= cfg_wdata;
		end
	end
	assign p_eff = (payload_q == '0) ? idsg_pkg::PAYLOAD_W'(1) : payload_q;

	// ceil division: numerator len + p - 1, one quotient bit per cycle
	assign div_init  = {1'b0, in_total_length} + idsg_pkg::DIV_W'(p_eff)
		- idsg_pkg::DIV_W'(1);
	assign div_shift = {rem_q, num_q[idsg_pkg::DIV_W-1]};
	assign div_ge    = (div_shift >= {1'b0, p_eff});
	assign div_diff  = div_shift - {1'b0, p_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.accept_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + idsg_pkg::DIV_CNT_W'(1);
			if (div_cnt_q == idsg_pkg::DIV_CNT_W'(idsg_pkg::DIV_STEPS - 1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_start) begin
			rem_q <= '0;
			num_q <= div_init;
		end else if (div_busy_q) begin
			rem_q <= div_ge ? div_diff[idsg_pkg::PAYLOAD_W-1:0]
				: div_shift[idsg_pkg::PAYLOAD_W-1:0];
			num_q <= {num_q[idsg_pkg::DIV_W-2:0], div_ge};
		end
	end

	// data byte bookkeeping
	assign pos_inc  = chunk_pos_q + idsg_pkg::PAYLOAD_W'(1);
	assign finished = (bytes_left_q == idsg_pkg::LEN_W'(1));
	assign closes   = finished || (pos_inc == '0) || (pos_inc >= p_eff);

	// image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			chunk_pos_q  <= '0;
			chunk_idx_q  <= '0;
			image_open_q <= 1'b0;
			len_zero_q   <= 1'b0;
			sel_q        <= '0;
		end else if (cmd.accept_start) begin
			bytes_left_q <= in_total_length;
			chunk_pos_q  <= '0;
			chunk_idx_q  <= '0;
			image_open_q <= (in_total_length != '0);
			len_zero_q   <= (in_total_length == '0);
			sel_q        <= '0;
		end else if (cmd.emit) begin
			case (cmd.kind)
				idsg_pkg::K_ERR: begin
					image_open_q <= 1'b0;
				end
				idsg_pkg::K_INDEX: begin
					sel_q <= (sel_q == SEL_LAST) ? '0 : sel_q + idsg_pkg::SEL_W'(1);
				end
				idsg_pkg::K_DATA: begin
					bytes_left_q <= bytes_left_q - idsg_pkg::LEN_W'(1);
					chunk_pos_q  <= closes ? '0 : pos_inc;
					if (closes) chunk_idx_q <= chunk_idx_q + idsg_pkg::IDX_W'(1);
					if (finished) image_open_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// captured input fields
	always_ff @(posedge clk) begin
		if (cmd.accept_start) type_q <= in_image_type;
		if (cmd.accept_data) data_q <= in_data_byte;
	end

	// index bytes, low first; bytes above the 24-bit index read zero
	always_comb begin
		case (sel_q)
			2'd0:    idx_byte = chunk_idx_q[7:0];
			2'd1:    idx_byte = chunk_idx_q[15:8];
			2'd2:    idx_byte = chunk_idx_q[23:16];
			default: idx_byte = '0;
		endcase
	end

	// result word select
	always_comb begin
		nxt_byte  = '0;
		nxt_end   = 1'b0;
		nxt_empty = 1'b0;
		nxt_last  = 1'b0;
		nxt_error = 1'b0;
		case (cmd.kind)
			idsg_pkg::K_TYPE:   nxt_byte = type_q;
			idsg_pkg::K_CNT_LO: nxt_byte = num_q[7:0];
			idsg_pkg::K_CNT_HI: begin
				nxt_byte = num_q[idsg_pkg::CNT_W-1:8];
				nxt_end  = 1'b1;
				nxt_last = len_zero_q;
			end
			idsg_pkg::K_EMPTY: begin
				nxt_end   = 1'b1;
				nxt_empty = 1'b1;
			end
			idsg_pkg::K_EMPTY_LAST: begin
				nxt_end   = 1'b1;
				nxt_empty = 1'b1;
				nxt_last  = 1'b1;
			end
			idsg_pkg::K_ERR: begin
				nxt_last  = 1'b1;
				nxt_error = 1'b1;
			end
			idsg_pkg::K_INDEX: nxt_byte = idx_byte;
			idsg_pkg::K_DATA: begin
				nxt_byte = data_q;
				nxt_end  = closes;
				nxt_last = !finished;
			end
			default: nxt_byte = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q  <= nxt_byte;
			out_end_q   <= nxt_end;
			out_empty_q <= nxt_empty;
			out_last_q  <= nxt_last;
			out_error_q <= nxt_error;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;
	assign out_empty = out_empty_q;
	assign out_last  = out_last_q;
	assign out_error = out_error_q;

	// status to the sequencer
	always_comb begin
		status.can_data   = image_open_q && (bytes_left_q != '0);
		status.pos_zero   = (chunk_pos_q == '0);
		status.len_zero   = len_zero_q;
		status.div_done   = !div_busy_q;
		status.last_index = (sel_q == SEL_LAST);
		status.finished   = finished;
		status.load_ok    = !out_valid_q || out_ready;
	end

endmodule

[sim/image_datagram_segmenter_tb.sv]
// ============================================================================
// image_datagram_segmenter_tb
// Self-checking bench for the datagram segmenter. A behavioral model of the
// segmenter predicts every result word from each accepted input word. A
// monitor compares result words in order against those predictions.
// Directed cases come first: the reset payload, zero length, payload extremes,
// count overflow, restart of an open image and a payload change mid-image.
// Random phases with sender gaps and receiver stalls follow.
// ============================================================================
module image_datagram_segmenter_tb;

	localparam int INDEX_BYTES  = 3;
	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_WORDS = 360;
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT      = 4_000_000;

	// one expected result word
	typedef struct packed {
		logic [idsg_pkg::BYTE_W-1:0] out_byte;
		logic                        datagram_end;
		logic                        empty_datagram;
		logic                        run_last;
		logic                        error;
	} dgram_word_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [15:0]          cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [39:0]          s_axis_tdata  = '0;   // image_type, total_length, data_byte
	logic [0:0]           s_axis_tuser  = '0;   // req_type
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;         // out_byte
	logic [2:0]           m_axis_tuser;         // datagram_end, empty_datagram, error
	logic                 m_axis_tlast;         // run_last

	// segmenter model state
	logic [idsg_pkg::PAYLOAD_W-1:0] payload_reg;
	logic [idsg_pkg::LEN_W-1:0]     bytes_left;
	logic [idsg_pkg::PAYLOAD_W-1:0] chunk_pos;
	logic [idsg_pkg::IDX_W-1:0]     chunk_idx;
	logic                           image_open;

	dgram_word_t          dgram_q[$];
	dgram_word_t          head_word;
	int                   fail_count     = 0;
	int                   word_count     = 0;
	int                   send_idle_pct  = 0;
	int                   recv_stall_pct = 0;

	image_datagram_segmenter #(
		.INDEX_BYTES(INDEX_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(TIMEOUT);
		$display("Test completed with failures");
		$finish;
	end

	task automatic push_word(input logic [7:0] b, input logic dend, input logic empty,
			input logic last, input logic err);
		dgram_q.push_back({b, dend, empty, last, err});
	endtask

	// model: result words caused by one accepted input word
	task automatic segment_word(input logic req, input logic [7:0] typ,
			input logic [idsg_pkg::LEN_W-1:0] len, input logic [7:0] data);
		logic [31:0] plen;
		logic [31:0] count;
		logic        done;
		logic        closes;
		int          b;
		plen = (payload_reg == '0) ? 32'd1 : 32'(payload_reg);
		if (req == idsg_pkg::REQ_START) begin
			count = (32'(len) + plen - 32'd1) / plen;
			push_word(typ, 1'b0, 1'b0, 1'b0, 1'b0);
			push_word(count[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
			push_word(count[15:8], 1'b1, 1'b0, len == '0, 1'b0);
			chunk_pos  = '0;
			chunk_idx  = '0;
			bytes_left = len;
			image_open = (len != '0);
			// zero length: empty datagram, then the terminator
			if (len == '0) begin
				push_word(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
				push_word(8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
			end
		end else if (!image_open || bytes_left == '0) begin
			image_open = 1'b0;
			push_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
		end else begin
			// chunk opens with its little-endian index
			if (chunk_pos == '0) begin
				for (b = 0; b < INDEX_BYTES; b++) begin
					push_word((b < 3) ? 8'(chunk_idx >> (8 * b)) : 8'h00,
						1'b0, 1'b0, 1'b0, 1'b0);
				end
			end
			chunk_pos  = chunk_pos + idsg_pkg::PAYLOAD_W'(1);
			bytes_left = bytes_left - idsg_pkg::LEN_W'(1);
			done       = (bytes_left == '0);
			closes     = done || chunk_pos == '0 || 32'(chunk_pos) >= plen;
			push_word(data, closes, 1'b0, !done, 1'b0);
			if (closes) begin
				chunk_pos = '0;
				chunk_idx = chunk_idx + idsg_pkg::IDX_W'(1);
			end
			if (done) begin
				push_word(8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
				image_open = 1'b0;
			end
		end
	endtask

	// present one input word, optionally after random gaps, until accepted
	task automatic send_word(input logic req, input logic [7:0] typ,
			input logic [idsg_pkg::LEN_W-1:0] len, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {data, len, typ};
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		segment_word(req, typ, len, data);
		word_count++;
	endtask

	task automatic send_start(input logic [7:0] typ, input logic [idsg_pkg::LEN_W-1:0] len);
		send_word(idsg_pkg::REQ_START, typ, len, 8'($urandom));
	endtask

	task automatic send_data(input logic [7:0] data);
		send_word(idsg_pkg::REQ_DATA, 8'($urandom), idsg_pkg::LEN_W'($urandom), data);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (dgram_q.size() != 0) @(posedge clk);
	endtask

	// register write, only once every pending result word has come out
	task automatic write_payload(input logic [15:0] value);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		payload_reg = value;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_payload();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (dgram_q.size() == 0) begin
					$error("result word with none pending: byte %0h user %0b last %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fail_count++;
				end else begin
					head_word = dgram_q.pop_front();
					check_field("out_byte", head_word.out_byte, m_axis_tdata);
					check_field("datagram_end", 8'(head_word.datagram_end), 8'(m_axis_tuser[0]));
					check_field("empty_datagram", 8'(head_word.empty_datagram),
						8'(m_axis_tuser[1]));
					check_field("error", 8'(head_word.error), 8'(m_axis_tuser[2]));
					check_field("run_last", 8'(head_word.run_last), 8'(m_axis_tlast));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// header count with the payload size left at reset
	task automatic test_reset_payload();
		send_start(8'h4d, 24'd2500);
	endtask

	// zero-length image, then a stray data byte
	task automatic test_zero_length();
		write_payload(16'd4);
		send_start(8'hff, 24'd0);
		send_data(8'hff);
	endtask

	task automatic test_small_image();
		write_payload(16'd3);
		send_start(8'h00, 24'd4);
		send_data(8'h00);
		send_data(8'hff);
		send_data(8'h5a);
		send_data(8'ha5);
	endtask

	// payload register zero acts as one byte per chunk
	task automatic test_payload_zero();
		write_payload(16'd0);
		send_start(8'h49, 24'd2);
		send_data(8'h81);
		send_data(8'h7e);
	endtask

	task automatic test_payload_max();
		write_payload(16'hffff);
		send_start(8'h49, 24'hffffff);
		send_data(8'h33);
		send_data(8'hcc);
	endtask

	// count beyond 16 bits keeps its low half
	task automatic test_count_overflow();
		write_payload(16'd1);
		send_start(8'h4d, 24'hffffff);
		send_data(8'h01);
		send_data(8'hfe);
	endtask

	// start while an image is still open drops it
	task automatic test_restart_open();
		send_start(8'h4d, 24'd1);
		send_data(8'h42);
	endtask

	// shrink the payload while a chunk is partly filled
	task automatic test_payload_change();
		write_payload(16'd4);
		send_start(8'h49, 24'd5);
		send_data(8'h10);
		send_data(8'h20);
		send_data(8'h30);
		write_payload(16'd2);
		send_data(8'h40);
		send_data(8'h50);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int stop_at;
		int len;
		int sent;
		int kind;
		write_payload(pick_payload());
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = word_count + RANDOM_WORDS / 4;
		while (word_count < stop_at) begin
			if ($urandom_range(99) < 12) write_payload(pick_payload());
			kind = $urandom_range(99);
			if (kind < 75) begin
				// complete image, now and then a payload change halfway
				len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
				send_start(8'($urandom), idsg_pkg::LEN_W'(len));
				for (sent = 0; sent < len; sent++) begin
					if (sent == len / 2 && $urandom_range(19) == 0)
						write_payload(pick_payload());
					send_data(8'($urandom));
				end
			end else if (kind < 85) begin
				// image cut short, left open
				len = $urandom_range(2, 24);
				send_start(8'($urandom), idsg_pkg::LEN_W'(len));
				repeat ($urandom_range(0, len - 1)) send_data(8'($urandom));
			end else if (kind < 93) begin
				repeat ($urandom_range(1, 3)) send_data(8'($urandom));
			end else begin
				// full-range length, only the first bytes sent
				send_start(8'($urandom), idsg_pkg::LEN_W'($urandom));
				repeat ($urandom_range(0, 4)) send_data(8'($urandom));
			end
		end
	endtask

	initial begin
		payload_reg = idsg_pkg::PAYLOAD_RESET;
		bytes_left  = '0;
		chunk_pos   = '0;
		chunk_idx   = '0;
		image_open  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_payload();
		test_zero_length();
		test_small_image();
		test_payload_zero();
		test_payload_max();
		test_count_overflow();
		test_restart_open();
		test_payload_change();

		test_random_phase(0, 0);
		test_random_phase(74, 0);
		test_random_phase(0, 74);
		test_random_phase(16, 16);

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
